>>> rtl/sem_pkg.sv
// ----------------------------------------------------------------------------
// Sobel edge magnitude package
// Shared word types, field widths and register indexes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sem_pkg;

   // Pixel and derived widths
   localparam int PIXEL_W = 8;
   localparam int WORD_W  = 2 * PIXEL_W;  // line store word: {previous row, row before}
   localparam int GRAD_W  = 10;           // |gx|, |gy| <= 1020
   localparam int SQ_W    = 2 * GRAD_W;

   // Magnitude scaling and saturation
   localparam int MAG_SHIFT = 8;
   localparam logic [PIXEL_W-1:0] MAG_MAX = 8'd255;

   // Configuration register port
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 13;
   localparam int CSR_WIDTH_W  = 10;
   localparam int CSR_HEIGHT_W = 13;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;

   // Smallest legal image dimension
   localparam int DIM_MIN = 3;

   typedef logic [PIXEL_W-1:0] pixel_type;

   // Memory stage to window stage
   typedef struct packed {
      logic      done;   // memory stage item completes this cycle
      logic      res;    // item completes an interior window
      logic      last;   // final interior result of the frame
      pixel_type px;
      pixel_type top;
      pixel_type mid;
   } s1_word_type;

   // Window stage to magnitude stage
   typedef struct packed {
      logic [GRAD_W-1:0] ax;
      logic [GRAD_W-1:0] ay;
      logic              last;
   } grad_type;

endpackage

>>> rtl/sem_line_store.sv
// ----------------------------------------------------------------------------
// Sobel line store
// Dual-row line buffer in one synchronous RAM, one write and one registered
// read per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sem_line_store #(
   parameter int DEPTH = 512
) (
   input  logic                         clock,
   input  logic                         rd_en,
   input  logic [$clog2(DEPTH)-1:0]     rd_addr,
   output logic [sem_pkg::WORD_W-1:0]   rd_data,
   input  logic                         wr_en,
   input  logic [$clog2(DEPTH)-1:0]     wr_addr,
   input  logic [sem_pkg::WORD_W-1:0]   wr_data
);

   logic [sem_pkg::WORD_W-1:0] mem [DEPTH];
   logic [sem_pkg::WORD_W-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/sem_window.sv
// ----------------------------------------------------------------------------
// Sobel window and gradient stage
// Holds the 3x3 window, shifts in one column per pixel and registers the
// absolute horizontal and vertical gradients.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sem_window (
   input  logic                  clock,
   input  logic                  reset,
   input  sem_pkg::s1_word_type  s1,
   output logic                  win_ready,
   output logic                  grad_valid,
   output sem_pkg::grad_type     grad,
   input  logic                  grad_ready
);

   // win_ff[r*3 + c]: row r (0 top), column c (0 oldest)
   sem_pkg::pixel_type win_ff [9];
   sem_pkg::pixel_type win_in [9];

   logic              grad_valid_ff;
   logic              grad_valid_in;
   sem_pkg::grad_type grad_ff;
   sem_pkg::grad_type grad_in;

   logic [sem_pkg::GRAD_W-1:0] sum_r, sum_l, sum_b, sum_t;
   logic [sem_pkg::GRAD_W:0]   dx, dy, ndx, ndy;

   function automatic logic [sem_pkg::GRAD_W-1:0] weigh(
      input sem_pkg::pixel_type a,
      input sem_pkg::pixel_type b,
      input sem_pkg::pixel_type c
   );
      weigh = {2'b00, a} + {1'b0, b, 1'b0} + {2'b00, c};
   endfunction

   // Shifted window with the new column on the right
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         win_in[r*3 + 0] = win_ff[r*3 + 1];
         win_in[r*3 + 1] = win_ff[r*3 + 2];
      end
      win_in[2] = s1.top;
      win_in[5] = s1.mid;
      win_in[8] = s1.px;
   end

   // Gradients on the new window
   always_comb begin
      sum_r = weigh(win_in[2], win_in[5], win_in[8]);
      sum_l = weigh(win_in[0], win_in[3], win_in[6]);
      sum_b = weigh(win_in[6], win_in[7], win_in[8]);
      sum_t = weigh(win_in[0], win_in[1], win_in[2]);
      dx    = {1'b0, sum_r} - {1'b0, sum_l};
      dy    = {1'b0, sum_b} - {1'b0, sum_t};
      ndx   = -dx;
      ndy   = -dy;
      grad_in.ax   = dx[sem_pkg::GRAD_W] ? ndx[sem_pkg::GRAD_W-1:0]
                                         : dx[sem_pkg::GRAD_W-1:0];
      grad_in.ay   = dy[sem_pkg::GRAD_W] ? ndy[sem_pkg::GRAD_W-1:0]
                                         : dy[sem_pkg::GRAD_W-1:0];
      grad_in.last = s1.last;
   end

   // Output word valid: loaded by an interior window, cleared when taken
   always_comb begin
      grad_valid_in = grad_valid_ff;
      if (s1.done && s1.res) begin
         grad_valid_in = 1'b1;
      end else if (grad_ready) begin
         grad_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 9; i++) begin
            win_ff[i] <= '0;
         end
         grad_valid_ff <= 1'b0;
      end else begin
         if (s1.done) begin
            win_ff <= win_in;
         end
         grad_valid_ff <= grad_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1.done && s1.res) begin
         grad_ff <= grad_in;
      end
   end

   assign win_ready  = !grad_valid_ff || grad_ready;
   assign grad_valid = grad_valid_ff;
   assign grad       = grad_ff;

endmodule

>>> rtl/sem_magnitude.sv
// ----------------------------------------------------------------------------
// Sobel magnitude stage
// Squares the gradients, sums, scales by 1/256 and saturates into the
// result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sem_magnitude (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        grad_valid,
   input  sem_pkg::grad_type           grad,
   output logic                        grad_ready,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [sem_pkg::PIXEL_W-1:0] rsp_edge_res,
   output logic                        rsp_frame_last
);

   logic                      sq_valid_ff, sq_valid_in;
   logic [sem_pkg::SQ_W-1:0]  sqx_ff, sqy_ff;
   logic                      sq_last_ff;
   logic                      out_free;
   logic                      grad_take;
   logic                      sq_take;

   logic [sem_pkg::SQ_W:0]                    sum;
   logic [sem_pkg::SQ_W-sem_pkg::MAG_SHIFT:0] scaled;
   logic [sem_pkg::PIXEL_W-1:0]               mag;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [sem_pkg::PIXEL_W-1:0] rsp_edge_res_ff;
   logic                        rsp_frame_last_ff;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign grad_ready = !sq_valid_ff || out_free;
   assign grad_take  = grad_valid && grad_ready;
   assign sq_take    = sq_valid_ff && out_free;

   // Squares stage
   always_comb begin
      sq_valid_in = sq_valid_ff;
      if (grad_take) begin
         sq_valid_in = 1'b1;
      end else if (sq_take) begin
         sq_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (grad_take) begin
         sqx_ff     <= grad.ax * grad.ax;
         sqy_ff     <= grad.ay * grad.ay;
         sq_last_ff <= grad.last;
      end
   end

   // Sum, scale and saturate
   always_comb begin
      sum    = {1'b0, sqx_ff} + {1'b0, sqy_ff};
      scaled = sum[sem_pkg::SQ_W:sem_pkg::MAG_SHIFT];
      if (|scaled[sem_pkg::SQ_W-sem_pkg::MAG_SHIFT:sem_pkg::PIXEL_W]) begin
         mag = sem_pkg::MAG_MAX;
      end else begin
         mag = scaled[sem_pkg::PIXEL_W-1:0];
      end
   end

   // Result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (sq_take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (sq_take) begin
         rsp_edge_res_ff   <= mag;
         rsp_frame_last_ff <= sq_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sq_valid_ff  <= sq_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_edge_res   = rsp_edge_res_ff;
   assign rsp_frame_last = rsp_frame_last_ff;

endmodule

>>> rtl/sobel_edge_magnitude.sv
// ----------------------------------------------------------------------------
// Sobel edge magnitude
// 3x3 Sobel gradient magnitude over a raster pixel stream, result
// min((gx*gx + gy*gy) >> 8, 255) for every interior pixel.
// ----------------------------------------------------------------------------
//  channel   direction   payload                         handshake
//  req       in          req_pixel                       req_valid / req_ready
//  rsp       out         rsp_edge_res, rsp_frame_last    rsp_valid / rsp_ready
//  csr       in          csr_index, csr_wdata            csr_valid / csr_ready
//
//  One pixel a cycle is taken unless the output stalls; a result is offered
//  after its pixel passes the memory stage (line store read at acceptance),
//  then the window/gradient, square and sum-and-saturate result registers.
//  Each pixel does one read and one write of the line store RAM; the write
//  lands as the pixel leaves the memory stage, and the same column recurs
//  only a full row (at least 3 pixels) later, so no forwarding is needed.
//  Reset clears counters, window and valids; the line store is not cleared,
//  its first two rows of each frame are rewritten before any result uses them.
//  Every stage has its own valid bit, so a stalled result holds only the
//  stages behind it that are full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sobel_edge_magnitude #(
   parameter int MAX_LINE = 512,
   parameter int MAX_ROWS = 4096
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [sem_pkg::PIXEL_W-1:0]     req_pixel,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [sem_pkg::PIXEL_W-1:0]     rsp_edge_res,
   output logic                            rsp_frame_last,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [sem_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [sem_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int CW    = $clog2(MAX_LINE);
   localparam int RW    = $clog2(MAX_ROWS);
   localparam int WW    = $clog2(MAX_LINE + 1);
   localparam int HW    = $clog2(MAX_ROWS + 1);
   localparam int W_RST = (512 > MAX_LINE) ? MAX_LINE : 512;
   localparam int H_RST = (512 > MAX_ROWS) ? MAX_ROWS : 512;

   logic [WW-1:0] width_ff, width_in;
   logic [HW-1:0] height_ff, height_in;
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic          csr_hit;
   logic          acc;

   logic          col_end, row_end;
   logic          res_now, last_now;

   logic               s1_valid_ff, s1_valid_in;
   logic               s1_res_ff, s1_last_ff;
   logic [CW-1:0]      s1_col_ff;
   sem_pkg::pixel_type s1_px_ff;
   logic               s1_go, s1_done;
   logic               win_ready;

   logic [sem_pkg::WORD_W-1:0] rd_data;
   sem_pkg::s1_word_type       s1_word;

   logic              grad_valid, grad_ready;
   sem_pkg::grad_type grad;

   assign csr_ready = 1'b1;
   assign acc       = req_valid && req_ready;

   // Register writes, saturated into range
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      csr_hit   = 1'b0;
      if (csr_valid) begin
         case (csr_index)
            sem_pkg::CSR_IMAGE_WIDTH: begin
               csr_hit = 1'b1;
               if (int'(csr_wdata[sem_pkg::CSR_WIDTH_W-1:0]) < sem_pkg::DIM_MIN) begin
                  width_in = WW'(sem_pkg::DIM_MIN);
               end else if (int'(csr_wdata[sem_pkg::CSR_WIDTH_W-1:0]) > MAX_LINE) begin
                  width_in = WW'(MAX_LINE);
               end else begin
                  width_in = WW'(csr_wdata[sem_pkg::CSR_WIDTH_W-1:0]);
               end
            end
            sem_pkg::CSR_IMAGE_HEIGHT: begin
               csr_hit = 1'b1;
               if (int'(csr_wdata[sem_pkg::CSR_HEIGHT_W-1:0]) < sem_pkg::DIM_MIN) begin
                  height_in = HW'(sem_pkg::DIM_MIN);
               end else if (int'(csr_wdata[sem_pkg::CSR_HEIGHT_W-1:0]) > MAX_ROWS) begin
                  height_in = HW'(MAX_ROWS);
               end else begin
                  height_in = HW'(csr_wdata[sem_pkg::CSR_HEIGHT_W-1:0]);
               end
            end
            default: begin
               csr_hit = 1'b0;
            end
         endcase
      end
   end

   // Raster position and interior test
   assign col_end  = (WW'(col_ff) + WW'(1)) >= width_ff;
   assign row_end  = (HW'(row_ff) + HW'(1)) >= height_ff;
   assign res_now  = (col_ff >= CW'(2)) && (row_ff >= RW'(2));
   assign last_now = col_end && row_end;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (csr_hit) begin
         col_in = '0;
         row_in = '0;
      end else if (acc) begin
         if (col_end) begin
            col_in = '0;
            row_in = row_end ? '0 : row_ff + RW'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   // Memory stage: pixel waits here for its line store read
   assign s1_go     = !s1_res_ff || win_ready;
   assign s1_done   = s1_valid_ff && s1_go;
   assign req_ready = !s1_valid_ff || s1_go;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (acc) begin
         s1_valid_in = 1'b1;
      end else if (s1_done) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= WW'(W_RST);
         height_ff   <= HW'(H_RST);
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         width_ff    <= width_in;
         height_ff   <= height_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         s1_px_ff   <= req_pixel;
         s1_col_ff  <= col_ff;
         s1_res_ff  <= res_now;
         s1_last_ff <= last_now;
      end
   end

   // Line store word: upper byte previous row, lower byte row before
   sem_line_store #(
      .DEPTH (MAX_LINE)
   ) u_line_store (
      .clock   (clock),
      .rd_en   (acc),
      .rd_addr (col_ff),
      .rd_data (rd_data),
      .wr_en   (s1_done),
      .wr_addr (s1_col_ff),
      .wr_data ({s1_px_ff, rd_data[sem_pkg::WORD_W-1:sem_pkg::PIXEL_W]})
   );

   always_comb begin
      s1_word.done = s1_done;
      s1_word.res  = s1_res_ff;
      s1_word.last = s1_last_ff;
      s1_word.px   = s1_px_ff;
      s1_word.mid  = rd_data[sem_pkg::WORD_W-1:sem_pkg::PIXEL_W];
      s1_word.top  = rd_data[sem_pkg::PIXEL_W-1:0];
   end

   sem_window u_window (
      .clock      (clock),
      .reset      (reset),
      .s1         (s1_word),
      .win_ready  (win_ready),
      .grad_valid (grad_valid),
      .grad       (grad),
      .grad_ready (grad_ready)
   );

   sem_magnitude u_magnitude (
      .clock          (clock),
      .reset          (reset),
      .grad_valid     (grad_valid),
      .grad           (grad),
      .grad_ready     (grad_ready),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_edge_res   (rsp_edge_res),
      .rsp_frame_last (rsp_frame_last)
   );

endmodule

>>> tb/sobel_edge_magnitude_tb.sv
// ----------------------------------------------------------------------------
// Sobel edge magnitude testbench
// Streams raster frames of many sizes through the block and predicts every
// interior result from its own model of the line stores, window and counters.
// Results are checked field by field in order. Covers reset sizes, saturating
// register writes, restarts by register write mid-frame, ignored indexes,
// output backpressure and random frames with random idling on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sobel_edge_magnitude_tb;

   localparam int LINE_MAX      = 512;
   localparam int ROWS_MAX      = 4096;
   localparam int RESET_DIM     = 512;
   localparam int DRAIN_CYCLES  = 10;      // pipeline is 4 deep, with margin
   localparam int HOLD_CYCLES   = 200;     // long receiver hold-off
   localparam int RANDOM_PIXELS = 900;
   localparam int CYCLE_LIMIT   = 1_000_000;

   // Indexes with no register behind them
   localparam logic [sem_pkg::CSR_INDEX_W-1:0] CSR_UNUSED_A = 2'd2;
   localparam logic [sem_pkg::CSR_INDEX_W-1:0] CSR_UNUSED_B = 2'd3;

   typedef enum int {PIX_FULL, PIX_BINARY, PIX_NEAR} pix_mode_type;

   typedef struct {
      sem_pkg::pixel_type edge_res;
      logic               frame_last;
   } edge_result_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   sem_pkg::pixel_type              req_pixel = '0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   sem_pkg::pixel_type              rsp_edge_res;
   logic                            rsp_frame_last;
   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   logic [sem_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [sem_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;

   // Predictor state
   sem_pkg::pixel_type prev_row [LINE_MAX];
   sem_pkg::pixel_type older_row [LINE_MAX];
   sem_pkg::pixel_type win [9];
   int unsigned        col_at = 0;
   int unsigned        row_at = 0;
   int unsigned        cfg_width = RESET_DIM;
   int unsigned        cfg_height = RESET_DIM;
   edge_result_type    edge_expect_q [$];

   int  error_count = 0;
   int  cycle_count = 0;
   bit  quiet = 1'b0;          // no idling on either side
   bit  hold_pending = 1'b0;   // ask the receiver for a long hold-off

   sobel_edge_magnitude i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_pixel      (req_pixel),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_edge_res   (rsp_edge_res),
      .rsp_frame_last (rsp_frame_last),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------------
   function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
      if (v < sem_pkg::DIM_MIN) return sem_pkg::DIM_MIN;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic int weigh3(input sem_pkg::pixel_type a, input sem_pkg::pixel_type b,
                                 input sem_pkg::pixel_type c);
      return int'(a) + 2 * int'(b) + int'(c);
   endfunction

   function automatic void apply_reg(input logic [sem_pkg::CSR_INDEX_W-1:0] idx,
                                     input logic [sem_pkg::CSR_DATA_W-1:0] data);
      case (idx)
         sem_pkg::CSR_IMAGE_WIDTH: begin
            cfg_width = clamp_dim(32'(data[sem_pkg::CSR_WIDTH_W-1:0]), LINE_MAX);
         end
         sem_pkg::CSR_IMAGE_HEIGHT: begin
            cfg_height = clamp_dim(32'(data[sem_pkg::CSR_HEIGHT_W-1:0]), ROWS_MAX);
         end
         default: return;   // unknown index leaves the frame alone
      endcase
      col_at = 0;
      row_at = 0;
   endfunction

   // One accepted pixel: update stores and window, queue any interior result
   function automatic void predict_pixel(input sem_pkg::pixel_type px);
      int unsigned        c;
      sem_pkg::pixel_type above2;
      sem_pkg::pixel_type above1;
      int                 gx;
      int                 gy;
      int                 mag;
      edge_result_type    res;
      c = (col_at >= LINE_MAX) ? LINE_MAX - 1 : col_at;
      above2 = older_row[c];
      above1 = prev_row[c];
      older_row[c] = above1;
      prev_row[c] = px;
      for (int r = 0; r < 3; r++) begin
         win[r*3]   = win[r*3+1];
         win[r*3+1] = win[r*3+2];
      end
      win[2] = above2;
      win[5] = above1;
      win[8] = px;
      if (col_at >= 2 && row_at >= 2) begin
         gx = weigh3(win[2], win[5], win[8]) - weigh3(win[0], win[3], win[6]);
         gy = weigh3(win[6], win[7], win[8]) - weigh3(win[0], win[1], win[2]);
         mag = (gx * gx + gy * gy) >>> sem_pkg::MAG_SHIFT;
         res.edge_res   = (mag > int'(sem_pkg::MAG_MAX)) ? sem_pkg::MAG_MAX
                                                         : sem_pkg::pixel_type'(mag);
         res.frame_last = (col_at + 1 == cfg_width) && (row_at + 1 == cfg_height);
         edge_expect_q.push_back(res);
      end
      if (col_at + 1 >= cfg_width) begin
         col_at = 0;
         row_at = (row_at + 1 >= cfg_height) ? 0 : row_at + 1;
      end else begin
         col_at = col_at + 1;
      end
   endfunction

   function automatic sem_pkg::pixel_type pick_pixel(input pix_mode_type mode);
      case (mode)
         PIX_BINARY: return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
         PIX_NEAR:   return sem_pkg::pixel_type'($urandom_range(112, 143));
         default:    return sem_pkg::pixel_type'($urandom_range(0, 255));
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // Result checker
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      edge_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (edge_expect_q.size() == 0) begin
            $error("unexpected result word: edge_res=%0d frame_last=%0d",
                   rsp_edge_res, rsp_frame_last);
            error_count++;
         end else begin
            want = edge_expect_q.pop_front();
            if (rsp_edge_res !== want.edge_res) begin
               $error("edge_res: expected %0d, got %0d", want.edge_res, rsp_edge_res);
               error_count++;
            end
            if (rsp_frame_last !== want.frame_last) begin
               $error("frame_last: expected %0d, got %0d", want.frame_last, rsp_frame_last);
               error_count++;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Receiver: random stall bursts, plus a long hold-off on request
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      static int hold_left = 0;
      static int stall_left = 0;
      if (hold_pending) begin
         hold_left = HOLD_CYCLES;
         hold_pending = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(1, 7) - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // ------------------------------------------------------------------------
   // Sender side
   // ------------------------------------------------------------------------
   // Valid stays high between back-to-back words; it drops only for a gap
   task automatic send_pixel(input sem_pkg::pixel_type px);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_pixel <= px;
      do @(posedge clock); while (!req_ready);
      predict_pixel(px);
      @(negedge clock);
   endtask

   task automatic send_pixels(input int unsigned count, input pix_mode_type mode);
      for (int unsigned i = 0; i < count; i++) send_pixel(pick_pixel(mode));
   endtask

   // Stop sending and let every result, and any word still in flight, drain
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (edge_expect_q.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [sem_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [sem_pkg::CSR_DATA_W-1:0] data);
      wait_drained();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      apply_reg(idx, data);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_size(input logic [sem_pkg::CSR_DATA_W-1:0] w,
                           input logic [sem_pkg::CSR_DATA_W-1:0] h);
      write_reg(sem_pkg::CSR_IMAGE_WIDTH, w);
      write_reg(sem_pkg::CSR_IMAGE_HEIGHT, h);
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------
   // Reset sizes: part of the first row of 512, no result may appear
   task automatic test_reset_defaults();
      send_pixels(40, PIX_FULL);
   endtask

   // 3x3 frames, one result each: flat, saturating steps, rounding edges
   task automatic test_window_patterns();
      sem_pkg::pixel_type pat [7][9] = '{
         '{8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0},
         '{8'd255, 8'd0,   8'd0,   8'd255, 8'd0,   8'd0,   8'd255, 8'd0,   8'd0},
         '{8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd255, 8'd255, 8'd255},
         '{8'd0,   8'd0,   8'd64,  8'd0,   8'd0,   8'd64,  8'd0,   8'd0,   8'd63},
         '{8'd0,   8'd0,   8'd64,  8'd0,   8'd0,   8'd64,  8'd0,   8'd0,   8'd64},
         '{8'd0,   8'd0,   8'd0,   8'd0,   8'd255, 8'd0,   8'd0,   8'd0,   8'd0},
         '{8'd4,   8'd4,   8'd4,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0}
      };
      set_size(13'd3, 13'd3);
      // frames follow back to back, so the counters wrap at each frame end
      for (int p = 0; p < 7; p++) begin
         for (int k = 0; k < 9; k++) send_pixel(pat[p][k]);
      end
   endtask

   // Out-of-range writes saturate; widest and tallest frames start correctly
   task automatic test_register_extremes();
      set_size(13'h03FF, 13'd0);    // width 512, height 3
      send_pixels(40, PIX_FULL);
      set_size(13'd0, 13'h1FFF);    // width 3, height 4096
      send_pixels(24, PIX_BINARY);
      set_size(13'h1C02, 13'd2);    // upper bits dropped, then both clamp to 3
      send_pixels(18, PIX_FULL);
   endtask

   // Known register restarts the frame; unknown indexes leave it running
   task automatic test_midframe_write();
      set_size(13'd5, 13'd5);
      send_pixels(12, PIX_FULL);
      write_reg(sem_pkg::CSR_IMAGE_HEIGHT, 13'd5);
      send_pixels(7, PIX_FULL);
      write_reg(CSR_UNUSED_A, sem_pkg::CSR_DATA_W'($urandom_range(0, 8191)));
      write_reg(CSR_UNUSED_B, 13'h1FFF);
      send_pixels(18, PIX_FULL);
   endtask

   // Receiver holds off while words keep coming, so the input must stall
   task automatic test_backpressure();
      set_size(13'd7, 13'd12);
      hold_pending = 1'b1;
      send_pixels(7 * 12, PIX_NEAR);
   endtask

   // Random frame sizes, contents, aborts and spare writes
   task automatic test_random_frames();
      int unsigned                    sent;
      int unsigned                    w;
      int unsigned                    h;
      int unsigned                    n;
      logic [sem_pkg::CSR_DATA_W-1:0] wdata;
      logic [sem_pkg::CSR_DATA_W-1:0] hdata;
      pix_mode_type                   mode;
      sent = 0;
      while (sent < RANDOM_PIXELS) begin
         if (sent >= RANDOM_PIXELS * 3 / 4) quiet = 1'b1;
         case ($urandom_range(0, 9))
            0: begin
               w = $urandom_range(41, 128);
               h = 3;
            end
            1, 2: begin
               w = $urandom_range(11, 40);
               h = $urandom_range(3, 6);
            end
            default: begin
               w = $urandom_range(3, 10);
               h = $urandom_range(3, 10);
            end
         endcase
         // junk above the width field must be dropped
         wdata = sem_pkg::CSR_DATA_W'(w);
         wdata[sem_pkg::CSR_DATA_W-1:sem_pkg::CSR_WIDTH_W] = 3'($urandom_range(0, 7));
         if ($urandom_range(0, 15) == 0) begin
            wdata[sem_pkg::CSR_WIDTH_W-1:0] = sem_pkg::CSR_WIDTH_W'($urandom_range(0, 2));
            w = sem_pkg::DIM_MIN;
         end
         hdata = sem_pkg::CSR_DATA_W'(h);
         if ($urandom_range(0, 15) == 0) begin
            hdata = sem_pkg::CSR_DATA_W'($urandom_range(0, 2));
            h = sem_pkg::DIM_MIN;
         end
         if ($urandom_range(0, 3) != 0) write_reg(sem_pkg::CSR_IMAGE_WIDTH, wdata);
         else w = cfg_width;
         write_reg(sem_pkg::CSR_IMAGE_HEIGHT, hdata);
         if ($urandom_range(0, 7) == 0) begin
            write_reg($urandom_range(0, 1) ? CSR_UNUSED_A : CSR_UNUSED_B,
                      sem_pkg::CSR_DATA_W'($urandom_range(0, 8191)));
         end
         mode = pix_mode_type'($urandom_range(0, 2));
         // whole frames, sometimes several in a row, or a frame cut short
         if ($urandom_range(0, 5) == 0) n = $urandom_range(1, w * h - 1);
         else n = w * h * $urandom_range(1, 3);
         if (n > RANDOM_PIXELS - sent) n = RANDOM_PIXELS - sent;
         send_pixels(n, mode);
         sent += n;
      end
   endtask

   initial begin
      foreach (prev_row[i]) begin
         prev_row[i] = '0;
         older_row[i] = '0;
      end
      foreach (win[i]) win[i] = '0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_defaults();
      test_window_patterns();
      test_register_extremes();
      test_midframe_write();
      test_backpressure();
      test_random_frames();

      wait_drained();
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
